// ===== rtl/lro_pkg.sv =====
package lro_pkg;

  localparam int SLOT_W    = 4;
  localparam int NUM_SLOTS = 1 << SLOT_W;
  localparam int COUNT_W   = 5;
  localparam int OP_W      = 2;
  localparam int ENTRIES_DEFAULT = 16;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_DEMOTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_TO_NEWEST,
    CMD_TO_OLDEST
  } cell_cmd_t;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_t         cmd;
    logic [SLOT_W-1:0] slot;
  } cell_ctl_t;

  // where a cell stands against the fill count
  typedef struct packed {
    logic live;
    logic at_end;
    logic at_fill;
  } cell_pos_t;

endpackage

// ===== rtl/lro_cell.sv =====
module lro_cell
  import lro_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  cell_pos_t         pos,
  input  logic [SLOT_W-1:0] left_val,
  input  logic [SLOT_W-1:0] right_val,
  input  logic              prefix_in,
  input  logic              suffix_in,
  output logic [SLOT_W-1:0] val,
  output logic [SLOT_W-1:0] val_next,
  output logic              prefix_out,
  output logic              suffix_out
);

  logic match;

  assign match      = pos.live && (val == ctl.slot);
  assign prefix_out = prefix_in | match;
  assign suffix_out = suffix_in | match;

  always_comb begin
    val_next = val;
    unique case (ctl.cmd)
      CMD_HOLD: val_next = val;
      CMD_APPEND: begin
        if (pos.at_fill) val_next = ctl.slot;
      end
      CMD_TO_NEWEST: begin
        if (prefix_out && pos.live) val_next = pos.at_end ? ctl.slot : right_val;
      end
      CMD_TO_OLDEST: begin
        if (suffix_out && pos.live) val_next = left_val;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/lru_recency_order_unit.sv =====
// Latency: results are registered, offered the cycle after acceptance if output is free.
// Throughput: one item per cycle; a two-deep output buffer keeps input open while one
// result waits, and in_stall rises only while two results wait.
// Per-cycle work is set by the match chain that ripples along the row of order cells.
// Reset: order empty, count zero, no result pending; cell contents stay unset.
module lru_recency_order_unit
  import lro_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    operation,
  input  logic [SLOT_W-1:0]  slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SLOT_W-1:0]  oldest_slot,
  output logic [SLOT_W-1:0]  newest_slot,
  output logic [COUNT_W-1:0] listed_count,
  output logic               is_empty,
  output logic               refused
);

  typedef struct packed {
    logic [SLOT_W-1:0]  oldest;
    logic [SLOT_W-1:0]  newest;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               refused;
  } result_t;

  logic [COUNT_W-1:0]   count, count_next;
  logic [NUM_SLOTS-1:0] listed_bits, listed_next;
  logic                 in_fire, out_fire;
  logic                 inrange, listed, full, refuse;
  cell_ctl_t            ctl;
  cell_pos_t            pos [ENTRIES];
  logic [SLOT_W-1:0]    vals [ENTRIES];
  logic [SLOT_W-1:0]    vals_next [ENTRIES];
  logic [ENTRIES:0]     prefix, suffix;
  result_t              res_new, res_out, res_skid;
  logic                 skid_valid;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign inrange = int'(slot) < ENTRIES;
  assign listed  = inrange && listed_bits[slot];
  assign full    = int'(count) >= ENTRIES;

  always_comb begin
    count_next  = count;
    listed_next = listed_bits;
    refuse      = 1'b0;
    ctl.cmd     = CMD_HOLD;
    ctl.slot    = slot;
    if (in_fire) begin
      unique case (op_t'(operation))
        OP_CLEAR: begin
          count_next  = '0;
          listed_next = '0;
        end
        OP_APPEND: begin
          if (!inrange || listed || full) begin
            refuse = 1'b1;
          end else begin
            ctl.cmd           = CMD_APPEND;
            listed_next[slot] = 1'b1;
            count_next        = count + COUNT_W'(1);
          end
        end
        OP_TOUCH: begin
          if (!listed) refuse = 1'b1;
          else ctl.cmd = CMD_TO_NEWEST;
        end
        OP_DEMOTE: begin
          if (!listed) refuse = 1'b1;
          else ctl.cmd = CMD_TO_OLDEST;
        end
        default: refuse = 1'b0;
      endcase
    end
  end

  assign prefix[0]       = 1'b0;
  assign suffix[ENTRIES] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [SLOT_W-1:0] left_val, right_val;

    assign pos[i].live    = i < int'(count);
    assign pos[i].at_end  = (i + 1) == int'(count);
    assign pos[i].at_fill = i == int'(count);

    if (i == 0) begin : g_first
      assign left_val = slot;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right_val = slot;
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end

    lro_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos[i]),
      .left_val   (left_val),
      .right_val  (right_val),
      .prefix_in  (prefix[i]),
      .suffix_in  (suffix[i+1]),
      .val        (vals[i]),
      .val_next   (vals_next[i]),
      .prefix_out (prefix[i+1]),
      .suffix_out (suffix[i])
    );
  end

  always_comb begin
    res_new.newest = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if ((i + 1) == int'(count_next)) res_new.newest = res_new.newest | vals_next[i];
    end
    res_new.empty   = count_next == '0;
    res_new.oldest  = res_new.empty ? '0 : vals_next[0];
    res_new.count   = count_next;
    res_new.refused = refuse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      listed_bits <= '0;
    end else begin
      count       <= count_next;
      listed_bits <= listed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
        res_out   <= res_new;
      end else begin
        skid_valid <= 1'b1;
        res_skid   <= res_new;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        res_out    <= res_skid;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign oldest_slot  = res_out.oldest;
  assign newest_slot  = res_out.newest;
  assign listed_count = res_out.count;
  assign is_empty     = res_out.empty;
  assign refused      = res_out.refused;

  a_count_matches_bits: assert property (@(posedge clk) disable iff (rst)
    $countones(listed_bits) == int'(count))
    else $error("fill count out of step with listed bits");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output is empty");

  a_refuse_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && refuse) |=> (count == $past(count) && listed_bits == $past(listed_bits)))
    else $error("refused item changed the order");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_fire && operation == OP_CLEAR) |=> (count == '0 && listed_bits == '0))
    else $error("clear left slots listed");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lro_pkg::*;

  localparam int N              = ENTRIES_DEFAULT;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [SLOT_W-1:0]  oldest;
    logic [SLOT_W-1:0]  newest;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               refused;
  } order_view_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    operation = '0;
  logic [SLOT_W-1:0]  slot      = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SLOT_W-1:0]  oldest_slot;
  logic [SLOT_W-1:0]  newest_slot;
  logic [COUNT_W-1:0] listed_count;
  logic               is_empty;
  logic               refused;

  // predicted recency order, head at index 0
  logic [SLOT_W-1:0] rec_order [N];
  bit                rec_listed [N];
  int                rec_count = 0;

  order_view_t pending_views [$];
  int          errors        = 0;
  bit          tx_idle_en    = 1'b0;
  bit          rx_idle_en    = 1'b0;
  bit          long_hold_req = 1'b0;
  int          idle_cycles   = 0;

  lru_recency_order_unit #(.ENTRIES(N)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .oldest_slot  (oldest_slot),
    .newest_slot  (newest_slot),
    .listed_count (listed_count),
    .is_empty     (is_empty),
    .refused      (refused)
  );

  always #2 clk = ~clk;

  function automatic order_view_t apply_recency(op_t op, logic [SLOT_W-1:0] s);
    order_view_t v;
    int          p;
    v = '0;
    p = 0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < N; i++) rec_listed[i] = 1'b0;
        rec_count = 0;
      end
      OP_APPEND: begin
        if (rec_listed[s] || rec_count >= N) begin
          v.refused = 1'b1;
        end else begin
          rec_order[rec_count] = s;
          rec_listed[s] = 1'b1;
          rec_count++;
        end
      end
      default: begin
        if (!rec_listed[s]) begin
          v.refused = 1'b1;
        end else begin
          for (int i = 0; i < rec_count; i++) if (rec_order[i] == s) p = i;
          if (op == OP_TOUCH) begin
            for (int i = p; i + 1 < rec_count; i++) rec_order[i] = rec_order[i + 1];
            rec_order[rec_count - 1] = s;
          end else begin
            for (int i = p; i > 0; i--) rec_order[i] = rec_order[i - 1];
            rec_order[0] = s;
          end
        end
      end
    endcase
    if (rec_count == 0) begin
      v.empty = 1'b1;
    end else begin
      v.oldest = rec_order[0];
      v.newest = rec_order[rec_count - 1];
    end
    v.count = rec_count[COUNT_W-1:0];
    return v;
  endfunction

  // mostly well-formed: appends of unlisted slots, moves of listed ones
  function automatic void pick_item(output op_t op, output logic [SLOT_W-1:0] s);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)       op = OP_CLEAR;
    else if (r < 38) op = OP_APPEND;
    else if (r < 69) op = OP_TOUCH;
    else             op = OP_DEMOTE;
    s = SLOT_W'($urandom_range(0, N - 1));
    if ($urandom_range(0, 9) < 8) begin
      if (op == OP_APPEND) begin
        if (rec_count < N) while (rec_listed[s]) s = SLOT_W'($urandom_range(0, N - 1));
      end else if (op != OP_CLEAR && rec_count > 0) begin
        s = rec_order[$urandom_range(0, rec_count - 1)];
      end
    end
  endfunction

  task automatic send_item(op_t op, logic [SLOT_W-1:0] s);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    slot      <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_views.push_back(apply_recency(op, s));
  endtask

  task automatic end_burst;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, bit has_want, order_view_t want,
                               order_view_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      if (has_want)
        $display("%s: expected oldest=%0d newest=%0d count=%0d empty=%0b refused=%0b",
                 what, want.oldest, want.newest, want.count, want.empty, want.refused);
      $display("%s: got      oldest=%0d newest=%0d count=%0d empty=%0b refused=%0b",
               what, got.oldest, got.newest, got.count, got.empty, got.refused);
    end
  endtask

  task automatic test_directed_cases;
    send_item(OP_CLEAR,  4'd15);  // clear ignores the slot field
    send_item(OP_TOUCH,  4'd3);   // empty order, refused
    send_item(OP_DEMOTE, 4'd0);
    send_item(OP_APPEND, 4'd0);
    send_item(OP_APPEND, 4'd0);   // already listed
    send_item(OP_TOUCH,  4'd0);   // already newest
    send_item(OP_DEMOTE, 4'd0);   // already oldest
    send_item(OP_APPEND, 4'd15);
    send_item(OP_TOUCH,  4'd0);
    send_item(OP_DEMOTE, 4'd0);
    send_item(OP_TOUCH,  4'd9);   // not listed
    send_item(OP_DEMOTE, 4'd9);
    send_item(OP_CLEAR,  4'd0);
    end_burst;
  endtask

  task automatic test_fill_to_capacity;
    logic [SLOT_W-1:0] perm [N];
    logic [SLOT_W-1:0] tmp;
    int                j;
    for (int i = 0; i < N; i++) perm[i] = SLOT_W'(i);
    for (int i = N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < N; i++) send_item(OP_APPEND, perm[i]);
    send_item(OP_APPEND, perm[$urandom_range(0, N - 1)]);  // full
    send_item(OP_TOUCH,  perm[0]);
    send_item(OP_DEMOTE, perm[N - 1]);
    send_item(OP_TOUCH,  perm[N - 1]);
    end_burst;
  endtask

  task automatic test_random_traffic(int n_items);
    op_t               op;
    logic [SLOT_W-1:0] s;
    for (int k = 0; k < n_items; k++) begin
      pick_item(op, s);
      send_item(op, s);
    end
    end_burst;
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_receiver_hold(int n_items);
    op_t               op;
    logic [SLOT_W-1:0] s;
    tx_idle_en    = 1'b0;
    long_hold_req = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      pick_item(op, s);
      send_item(op, s);
    end
    end_burst;
    tx_idle_en = 1'b1;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    order_view_t want;
    order_view_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = {oldest_slot, newest_slot, listed_count, is_empty, refused};
        if (pending_views.size() == 0) begin
          note_mismatch("unexpected result", 1'b0, '0, got);
        end else begin
          want = pending_views.pop_front();
          if (got !== want) note_mismatch("mismatch", 1'b1, want, got);
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("lru_recency_order_unit test failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_directed_cases;
    wait_drained;
    test_fill_to_capacity;
    wait_drained;
    test_random_traffic(650);
    test_receiver_hold(60);
    wait_drained;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(600);
    wait_drained;
    repeat (8) @(posedge clk);
    if (pending_views.size() != 0) errors++;
    if (errors == 0) begin
      $display("lru_recency_order_unit test passed");
    end else begin
      $display("lru_recency_order_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lro_pkg.sv
rtl/lro_cell.sv
rtl/lru_recency_order_unit.sv
tb/tb_top.sv
